@@ rtl/avtp_audio_depacketizer_unit_macros.svh @@
// assertion macros for the depacketizer
`ifndef AVTP_AUDIO_DEPACKETIZER_UNIT_MACROS_SVH
`define AVTP_AUDIO_DEPACKETIZER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AVTPAD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AVTPAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/avtpad_pkg.sv @@
package avtpad_pkg;

    localparam int SAMPLES_PER_CHANNEL_DEF = 6;
    localparam int CHANNEL_COUNT_DEF       = 2;
    localparam int PAYLOAD_OFFSET_DEF      = 50;

    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAX       = 7'd127;
    localparam logic [POS_W-1:0] ETHERTYPE_POS = 7'd16;
    localparam logic [POS_W-1:0] STREAM_ID_POS = 7'd22;
    localparam logic [POS_W-1:0] STREAM_ID_END = 7'd30;

    localparam int SAMPLE_W = 24;
    localparam int IDX_W    = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int CFG_INDEX_W = 2;
    localparam logic [15:0] ETHER_TYPE_RESET = 16'h22F0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ETHER_TYPE = 2'd0,
        CFG_STREAM_ID  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    idx;
    } item_t;

    typedef struct packed {
        logic              full;
        logic              nonempty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

endpackage

@@ rtl/avtp_audio_depacketizer_unit.sv @@
// avtp audio depacketizer
// input channel: one frame byte per transfer on data_byte, frame_end set on
//   the last byte; a byte transfers when push is high and full is low
// config channel: cfg_valid/cfg_ready with cfg_index (0 ether_type,
//   1 stream_identifier) and cfg_data; cfg_ready is always high
// result channel: the oldest sample sits on sample_value, channel_number and
//   last_sample while empty is low; pop high transfers it
// throughput: one byte per cycle while full is low, no gaps between frames
// path: the fourth byte of a payload word is written into a queue entry and then
//   registered by the back stage for the result ports, when the result side is idle
// the front parser takes the byte, checks header bytes and assembles words;
//   finished words go into a four-entry queue, and the back stage registers
//   them for the result ports
// when pop is held low the queue fills, then full rises and the input stalls
// reset: parser at byte 0 with the frame accepted, queue and output empty,
//   ether_type back to 0x22f0 and stream_identifier back to zero
`include "avtp_audio_depacketizer_unit_macros.svh"

module avtp_audio_depacketizer_unit #(
    parameter int SAMPLES_PER_CHANNEL = avtpad_pkg::SAMPLES_PER_CHANNEL_DEF,
    parameter int CHANNEL_COUNT       = avtpad_pkg::CHANNEL_COUNT_DEF,
    parameter int PAYLOAD_OFFSET      = avtpad_pkg::PAYLOAD_OFFSET_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [avtpad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                        cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         data_byte,
    input  logic                               frame_end,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [31:0]                 sample_value,
    output logic                               channel_number,
    output logic                               last_sample
);

    logic                    take;
    logic                    q_push;
    logic                    q_pop;
    avtpad_pkg::item_t       front_item;
    avtpad_pkg::item_t       q_item;
    avtpad_pkg::queue_stat_t q_stat;

    assign cfg_ready = 1'b1;
    assign full      = q_stat.full;
    assign take      = push && !q_stat.full;

    avtpad_front #(
        .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
        .CHANNEL_COUNT       (CHANNEL_COUNT),
        .PAYLOAD_OFFSET      (PAYLOAD_OFFSET)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .item_push (q_push),
        .item      (front_item)
    );

    avtpad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    avtpad_back #(
        .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
        .CHANNEL_COUNT       (CHANNEL_COUNT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_item         (q_item),
        .q_nonempty     (q_stat.nonempty),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .sample_value   (sample_value),
        .channel_number (channel_number),
        .last_sample    (last_sample)
    );

    `AVTPAD_ASSERT_NEXT(a_drain_to_empty, (pop && !empty && !q_stat.nonempty), empty, "output not empty after last transfer")
    `AVTPAD_ASSERT_NEXT(a_count_hold, (!q_push && !q_pop), $stable(q_stat.count), "queue count moved without push or pop")
    `AVTPAD_ASSERT_NEXT(a_push_lands, (q_push && !q_stat.full), (q_stat.nonempty || !empty), "pushed sample lost")

endmodule

@@ rtl/avtpad_front.sv @@
module avtpad_front #(
    parameter int SAMPLES_PER_CHANNEL = avtpad_pkg::SAMPLES_PER_CHANNEL_DEF,
    parameter int CHANNEL_COUNT       = avtpad_pkg::CHANNEL_COUNT_DEF,
    parameter int PAYLOAD_OFFSET      = avtpad_pkg::PAYLOAD_OFFSET_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [avtpad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                        cfg_data,
    input  logic                               take,
    input  logic [7:0]                         data_byte,
    input  logic                               frame_end,
    output logic                               item_push,
    output avtpad_pkg::item_t                  item
);

    localparam int WORD_COUNT  = SAMPLES_PER_CHANNEL * CHANNEL_COUNT;
    localparam int PAYLOAD_END = PAYLOAD_OFFSET + 4 * WORD_COUNT;
    localparam logic [7:0] OFF8 = 8'(PAYLOAD_OFFSET);
    localparam logic [7:0] END8 = 8'(PAYLOAD_END);

    logic [avtpad_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                         match_reg, match_next;
    logic [15:0]                  word_reg, word_next;
    logic [15:0]                  ether_type_reg;
    logic [63:0]                  stream_id_reg;

    logic [7:0] pos8;
    logic [7:0] k;
    logic [2:0] sid_k;
    logic [7:0] sid_byte;
    logic       in_sid;
    logic       in_payload;
    logic       emit;

    always_comb
    begin
        pos8       = {1'b0, pos_reg};
        k          = pos8 - OFF8;
        sid_k      = 3'(pos_reg - avtpad_pkg::STREAM_ID_POS);
        sid_byte   = stream_id_reg[{~sid_k, 3'b000} +: 8];
        in_sid     = (pos_reg >= avtpad_pkg::STREAM_ID_POS)
                     && (pos_reg < avtpad_pkg::STREAM_ID_END);
        in_payload = (pos8 >= OFF8) && (pos8 < END8);

        pos_next   = pos_reg;
        match_next = match_reg;
        word_next  = word_reg;
        emit       = 1'b0;

        if (take)
        begin
            if (pos_reg != avtpad_pkg::POS_MAX)
            begin
                if (pos_reg == avtpad_pkg::ETHERTYPE_POS)
                begin
                    if (data_byte != ether_type_reg[15:8])
                        match_next = 1'b0;
                end
                else if (pos_reg == avtpad_pkg::ETHERTYPE_POS + 7'd1)
                begin
                    if (data_byte != ether_type_reg[7:0])
                        match_next = 1'b0;
                end
                else if (in_sid)
                begin
                    if (data_byte != sid_byte)
                        match_next = 1'b0;
                end
                else if (in_payload)
                begin
                    if (k[1:0] != 2'b11)
                    begin
                        word_next = {word_reg[7:0], data_byte};
                    end
                    else
                    begin
                        word_next = '0;
                        emit      = match_reg;
                    end
                end
                pos_next = pos_reg + 7'd1;
            end
            if (frame_end)
            begin
                pos_next   = '0;
                match_next = 1'b1;
                word_next  = '0;
            end
        end

        item_push   = emit;
        item.sample = {word_reg, data_byte};
        item.idx    = k[6:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            match_reg      <= 1'b1;
            word_reg       <= '0;
            ether_type_reg <= avtpad_pkg::ETHER_TYPE_RESET;
            stream_id_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
            word_reg  <= word_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    avtpad_pkg::CFG_ETHER_TYPE: ether_type_reg <= cfg_data[15:0];
                    avtpad_pkg::CFG_STREAM_ID:  stream_id_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/avtpad_queue.sv @@
module avtpad_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  avtpad_pkg::item_t       push_item,
    input  logic                    pop,
    output avtpad_pkg::item_t       pop_item,
    output avtpad_pkg::queue_stat_t stat
);

    avtpad_pkg::item_t mem_reg [avtpad_pkg::QUEUE_DEPTH];

    logic [avtpad_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [avtpad_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [avtpad_pkg::QCNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    always_comb
    begin
        stat.full     = (count_reg == avtpad_pkg::QCNT_W'(avtpad_pkg::QUEUE_DEPTH));
        stat.nonempty = (count_reg != '0);
        stat.count    = count_reg;

        do_push = push && !stat.full;
        do_pop  = pop && stat.nonempty;

        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;

        pop_item = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/avtpad_back.sv @@
module avtpad_back #(
    parameter int SAMPLES_PER_CHANNEL = avtpad_pkg::SAMPLES_PER_CHANNEL_DEF,
    parameter int CHANNEL_COUNT       = avtpad_pkg::CHANNEL_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  avtpad_pkg::item_t  q_item,
    input  logic               q_nonempty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] sample_value,
    output logic               channel_number,
    output logic               last_sample
);

    localparam int WORD_COUNT = SAMPLES_PER_CHANNEL * CHANNEL_COUNT;
    localparam logic [avtpad_pkg::IDX_W-1:0] LAST_IDX =
        avtpad_pkg::IDX_W'(WORD_COUNT - 1);

    logic                           valid_reg, valid_next;
    logic [avtpad_pkg::SAMPLE_W-1:0] sample_reg;
    logic                           channel_reg;
    logic                           last_reg;

    always_comb
    begin
        q_pop      = q_nonempty && (!valid_reg || pop);
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;

        empty          = !valid_reg;
        sample_value   = signed'({sample_reg, 8'h00});
        channel_number = channel_reg;
        last_sample    = last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg  <= q_item.sample;
            channel_reg <= (CHANNEL_COUNT > 1) ? q_item.idx[0] : 1'b0;
            last_reg    <= (q_item.idx == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

@@ dv/avtpad_sample_checker.sv @@
`timescale 1ns / 100ps

module avtpad_sample_checker #(
    parameter int SAMPLES_PER_CHANNEL = avtpad_pkg::SAMPLES_PER_CHANNEL_DEF,
    parameter int CHANNEL_COUNT       = avtpad_pkg::CHANNEL_COUNT_DEF,
    parameter int PAYLOAD_OFFSET      = avtpad_pkg::PAYLOAD_OFFSET_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [avtpad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                        cfg_data,
    input  logic                               push,
    input  logic                               full,
    input  logic [7:0]                         data_byte,
    input  logic                               frame_end,
    input  logic                               empty,
    input  logic                               pop,
    input  logic signed [31:0]                 sample_value,
    input  logic                               channel_number,
    input  logic                               last_sample,
    output int                                 mismatch_count,
    output int                                 pending_count
);

    localparam int WORD_COUNT  = SAMPLES_PER_CHANNEL * CHANNEL_COUNT;
    localparam int PAYLOAD_END = PAYLOAD_OFFSET + 4 * WORD_COUNT;

    typedef struct packed {
        logic signed [31:0] value;
        logic               chan;
        logic               last;
    } sample_exp_t;

    sample_exp_t sample_fifo[$];

    logic [15:0] type_reg = avtpad_pkg::ETHER_TYPE_RESET;
    logic [63:0] sid_reg = '0;
    int          byte_pos = 0;
    bit          hdr_ok = 1'b1;
    logic [23:0] word_acc = '0;

    initial mismatch_count = 0;
    initial pending_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %08h want %08h", what, got, want);
        mismatch_count++;
    endtask

    task automatic check_sample();
        sample_exp_t want;
        if (sample_fifo.size() == 0) begin
            report_mismatch("unexpected sample", sample_value, '0);
        end
        else begin
            want = sample_fifo.pop_front();
            if (sample_value !== want.value)
                report_mismatch("sample_value", sample_value, want.value);
            if (channel_number !== want.chan)
                report_mismatch("channel_number", 32'(channel_number), 32'(want.chan));
            if (last_sample !== want.last)
                report_mismatch("last_sample", 32'(last_sample), 32'(want.last));
        end
    endtask

    task automatic apply_write();
        if (cfg_index == avtpad_pkg::CFG_ETHER_TYPE)
            type_reg = cfg_data[15:0];
        else if (cfg_index == avtpad_pkg::CFG_STREAM_ID)
            sid_reg = cfg_data;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last_byte);
        int          p;
        int          k;
        int          idx;
        int          sh;
        logic [31:0] word;
        sample_exp_t r;
        p = byte_pos;
        if (p < int'(avtpad_pkg::POS_MAX)) begin
            if (p == int'(avtpad_pkg::ETHERTYPE_POS)) begin
                if (b != type_reg[15:8])
                    hdr_ok = 1'b0;
            end
            else if (p == int'(avtpad_pkg::ETHERTYPE_POS) + 1) begin
                if (b != type_reg[7:0])
                    hdr_ok = 1'b0;
            end
            else if (p >= int'(avtpad_pkg::STREAM_ID_POS) &&
                     p < int'(avtpad_pkg::STREAM_ID_END)) begin
                sh = 8 * (int'(avtpad_pkg::STREAM_ID_END) - 1 - p);
                if (b != sid_reg[sh +: 8])
                    hdr_ok = 1'b0;
            end
            else if (p >= PAYLOAD_OFFSET && p < PAYLOAD_END) begin
                k = p - PAYLOAD_OFFSET;
                if ((k % 4) != 3) begin
                    word_acc = {word_acc[15:0], b};
                end
                else begin
                    word = {word_acc, b};
                    idx = k / 4;
                    word_acc = '0;
                    if (hdr_ok) begin
                        r.value = {word[23:0], 8'h00};
                        r.chan = 1'((idx % CHANNEL_COUNT) & 1);
                        r.last = (idx == WORD_COUNT - 1);
                        sample_fifo.push_back(r);
                    end
                end
            end
            byte_pos = p + 1;
        end
        if (last_byte) begin
            byte_pos = 0;
            hdr_ok = 1'b1;
            word_acc = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            type_reg = avtpad_pkg::ETHER_TYPE_RESET;
            sid_reg = '0;
            byte_pos = 0;
            hdr_ok = 1'b1;
            word_acc = '0;
            sample_fifo.delete();
            pending_count <= 0;
        end
        else begin
            if (pop && !empty)
                check_sample();
            if (cfg_valid && cfg_ready)
                apply_write();
            if (push && !full)
                predict_byte(data_byte, frame_end);
            pending_count <= sample_fifo.size();
        end
    end

endmodule

@@ dv/tb_avtp_audio_depacketizer_unit.sv @@
`timescale 1ns / 100ps

module tb_avtp_audio_depacketizer_unit;

    localparam int SPC      = avtpad_pkg::SAMPLES_PER_CHANNEL_DEF;
    localparam int CHANS    = avtpad_pkg::CHANNEL_COUNT_DEF;
    localparam int PAY_OFF  = avtpad_pkg::PAYLOAD_OFFSET_DEF;
    localparam int FULL_LEN = PAY_OFF + 4 * SPC * CHANS;
    localparam int LONG_LEN = 140;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 60;

    localparam logic [avtpad_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [avtpad_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int FILL_RANDOM  = 0;
    localparam int FILL_EXTREME = 1;
    localparam int FILL_NOISE   = 2;
    localparam int NO_FAULT     = -1;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [avtpad_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]                        cfg_data = '0;
    logic                               push = 1'b0;
    logic                               full;
    logic [7:0]                         data_byte = '0;
    logic                               frame_end = 1'b0;
    logic                               empty;
    logic                               pop = 1'b0;
    logic signed [31:0]                 sample_value;
    logic                               channel_number;
    logic                               last_sample;

    int          mismatches;
    int          pending;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    logic [15:0] cur_type = avtpad_pkg::ETHER_TYPE_RESET;
    logic [63:0] cur_sid = '0;

    logic        hold_req = 1'b0;
    logic        hold_served;
    int          hold_cnt;
    int          pop_gap;
    int          pop_calm;

    avtp_audio_depacketizer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .sample_value   (sample_value),
        .channel_number (channel_number),
        .last_sample    (last_sample)
    );

    avtpad_sample_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .sample_value   (sample_value),
        .channel_number (channel_number),
        .last_sample    (last_sample),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap <= 0;
            pop_calm <= 0;
            hold_cnt <= 0;
            hold_served <= 1'b0;
        end
        else if (hold_req && !hold_served)
        begin
            hold_cnt <= HOLD_CYCLES;
            hold_served <= 1'b1;
            pop <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            pop <= 1'b0;
        end
        else if (pop_gap != 0)
        begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (pop && !empty)
            begin
                if (pop_calm > 0)
                    pop_calm <= pop_calm - 1;
                else
                begin
                    pop_gap <= pick_gap();
                    if ($urandom_range(0, 15) == 0)
                        pop_calm <= $urandom_range(20, 60);
                end
            end
        end
    end

    task automatic write_reg(input logic [avtpad_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last_byte, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        frame_end <= last_byte;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len, input int fault_at, input bit calm,
                              input int fill);
        logic [7:0] b;
        int         i;
        for (i = 0; i < len; i++)
        begin
            if (fill == FILL_EXTREME)
            begin
                case ($urandom_range(0, 3))
                    0: b = 8'h00;
                    1: b = 8'hff;
                    2: b = 8'h7f;
                    default: b = 8'h80;
                endcase
            end
            else
                b = 8'($urandom);
            if (fill != FILL_NOISE)
            begin
                if (i == 16)
                    b = cur_type[15:8];
                else if (i == 17)
                    b = cur_type[7:0];
                else if (i >= 22 && i < 30)
                    b = cur_sid[8 * (29 - i) +: 8];
            end
            if (i == fault_at)
                b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, i == len - 1, calm);
        end
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_directed();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        send_frame(FULL_LEN, NO_FAULT, 1'b1, FILL_EXTREME);
        send_frame(FULL_LEN, NO_FAULT, 1'b0, FILL_EXTREME);
        // header mismatch on first ethertype byte and on last stream id byte
        send_frame(FULL_LEN, 16, 1'b1, FILL_RANDOM);
        send_frame(FULL_LEN, 29, 1'b0, FILL_RANDOM);
        // short frames: end inside a word, end on the byte that completes one
        send_frame(PAY_OFF + 6, NO_FAULT, 1'b1, FILL_RANDOM);
        send_frame(PAY_OFF + 4, NO_FAULT, 1'b1, FILL_RANDOM);
        send_frame(LONG_LEN, NO_FAULT, 1'b0, FILL_EXTREME);
    endtask

    task automatic run_random(input int target);
        int start;
        int r;
        int k;
        bit calm;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            r = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            if (r < 55)
                send_frame(FULL_LEN, NO_FAULT, calm, FILL_RANDOM);
            else if (r < 70)
                send_frame($urandom_range(1, FULL_LEN - 1), NO_FAULT, calm, FILL_RANDOM);
            else if (r < 80)
                send_frame($urandom_range(FULL_LEN + 1, LONG_LEN), NO_FAULT, calm,
                           FILL_RANDOM);
            else if (r < 92)
            begin
                k = $urandom_range(0, 9);
                send_frame(FULL_LEN, (k < 2) ? 16 + k : 20 + k, calm, FILL_RANDOM);
            end
            else
                send_frame($urandom_range(1, LONG_LEN), NO_FAULT, calm, FILL_NOISE);
        end
    endtask

    task automatic configure(input int phase);
        logic [63:0] data;
        case (phase)
            1:
            begin
                cur_type = 16'hffff;
                cur_sid = '1;
            end
            2:
            begin
                cur_type = 16'h0000;
                cur_sid = '0;
                write_reg(CFG_SPARE_LO, {$urandom, $urandom});
                write_reg(CFG_SPARE_HI, '1);
            end
            3:
            begin
                cur_type = 16'($urandom);
                cur_sid = {$urandom, $urandom};
            end
            default:
            begin
                cur_type = avtpad_pkg::ETHER_TYPE_RESET;
                cur_sid = {$urandom, $urandom};
            end
        endcase
        data = {$urandom, $urandom};
        data[15:0] = cur_type;
        write_reg(avtpad_pkg::CFG_ETHER_TYPE, data);
        write_reg(avtpad_pkg::CFG_STREAM_ID, cur_sid);
    endtask

    initial
    begin
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_BYTES);
        for (phase = 1; phase <= 4; phase++)
        begin
            drain_and_settle();
            configure(phase);
            if (phase == 1)
            begin
                hold_req <= 1'b1;
                // gapless matching frame so the queue fills during the hold
                send_frame(FULL_LEN, NO_FAULT, 1'b1, FILL_RANDOM);
            end
            run_random(RANDOM_BYTES);
        end
        drain_and_settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
